FILE: hdl/gpio_port_with_interrupt_detect_top_macros.svh
// Assertion shorthands for the GPIO port checks.
`ifndef GPIO_PORT_WITH_INTERRUPT_DETECT_TOP_MACROS_SVH
`define GPIO_PORT_WITH_INTERRUPT_DETECT_TOP_MACROS_SVH

// Clocked, reset-qualified property.
`define GPIO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent holds, consequent in the next cycle.
`define GPIO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/gpio_pkg.sv
package gpio_pkg;

	localparam int PIN_COUNT = 32;
	localparam int WORD_W    = 32;
	localparam int OFS_W     = 7;

	localparam logic [WORD_W-1:0] PIN_MASK =
		(PIN_COUNT >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << PIN_COUNT) - 64'd1);

	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_SAMPLE = 2'd2
	} cmd_t;

	localparam logic [OFS_W-1:0] OFS_DATA   = 7'h00;
	localparam logic [OFS_W-1:0] OFS_DIR    = 7'h04;
	localparam logic [OFS_W-1:0] OFS_INTEN  = 7'h30;
	localparam logic [OFS_W-1:0] OFS_TYPE   = 7'h38;
	localparam logic [OFS_W-1:0] OFS_POL    = 7'h3c;
	localparam logic [OFS_W-1:0] OFS_STATUS = 7'h40;
	localparam logic [OFS_W-1:0] OFS_EOI    = 7'h4c;
	localparam logic [OFS_W-1:0] OFS_PINS   = 7'h50;

endpackage

FILE: hdl/gpio_if.sv
interface gpio_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [6:0]  reg_offset;
	logic [31:0] write_data;
	logic [31:0] pins_in;

	modport source (output valid, command, reg_offset, write_data, pins_in, input ready);
	modport sink   (input valid, command, reg_offset, write_data, pins_in, output ready);
endinterface

interface gpio_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic [31:0] pins_out;
	logic [31:0] pins_dir;
	logic        irq;

	modport source (output valid, read_data, pins_out, pins_dir, irq, input ready);
	modport sink   (input valid, read_data, pins_out, pins_dir, irq, output ready);
endinterface

FILE: hdl/gpio_port_with_interrupt_detect_top.sv
// Channel | Dir | Word
// req     | in  | command, reg_offset, write_data, pins_in
// rsp     | out | read_data, pins_out, pins_dir, irq
//
// One word in, one word out. Registered through the input register, then the result register.
// A new word is taken every cycle while the result register drains.
// Port state is updated as a word moves from the input register to the result register.
// arst_n clears all port registers and both valid flags.
// A stalled rsp holds its word; req.ready drops only when both registers are full.
module gpio_port_with_interrupt_detect_top (
	input  logic       clk,
	input  logic       arst_n,
	gpio_req_if.sink   req,
	gpio_rsp_if.source rsp
);
	import gpio_pkg::*;

	logic              valid_s1;
	logic [1:0]        command_s1;
	logic [OFS_W-1:0]  reg_offset_s1;
	logic [WORD_W-1:0] write_data_s1;
	logic [WORD_W-1:0] pins_in_s1;

	logic [WORD_W-1:0] out_data_q, direction_q, irq_enable_q, irq_is_edge_q;
	logic [WORD_W-1:0] irq_polarity_q, edge_latched_q, last_pins_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] read_data_q, pins_out_q, pins_dir_q;
	logic              irq_q;

	logic              advance, take_in, step;
	logic [OFS_W-1:0]  ofs_word;
	logic [WORD_W-1:0] wval, now_pins, rising, falling, hit;
	logic [WORD_W-1:0] status_cur, status_nxt, rdata;
	logic [WORD_W-1:0] out_data_d, direction_d, irq_enable_d, irq_is_edge_d;
	logic [WORD_W-1:0] irq_polarity_d, edge_latched_d, last_pins_d;

	assign advance   = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign take_in   = req.valid && req.ready;
	assign step      = valid_s1 && advance;

	assign ofs_word = {reg_offset_s1[OFS_W-1:2], 2'b00};
	assign wval     = write_data_s1 & PIN_MASK;
	assign now_pins = pins_in_s1 & PIN_MASK;
	assign rising   = now_pins & ~last_pins_q;
	assign falling  = last_pins_q & ~now_pins;
	assign hit      = (irq_polarity_q & rising) | (~irq_polarity_q & falling);

	assign status_cur = irq_enable_q & PIN_MASK &
		((~irq_is_edge_q & ~(last_pins_q ^ irq_polarity_q)) | (irq_is_edge_q & edge_latched_q));

	always_comb begin
		out_data_d     = out_data_q;
		direction_d    = direction_q;
		irq_enable_d   = irq_enable_q;
		irq_is_edge_d  = irq_is_edge_q;
		irq_polarity_d = irq_polarity_q;
		edge_latched_d = edge_latched_q;
		last_pins_d    = last_pins_q;
		rdata          = '0;
		unique case (cmd_t'(command_s1))
			CMD_READ: begin
				unique case (ofs_word)
					OFS_DATA:   rdata = out_data_q;
					OFS_DIR:    rdata = direction_q;
					OFS_INTEN:  rdata = irq_enable_q;
					OFS_TYPE:   rdata = irq_is_edge_q;
					OFS_POL:    rdata = irq_polarity_q;
					OFS_STATUS: rdata = status_cur;
					OFS_PINS:   rdata = last_pins_q;
					default:    rdata = '0;
				endcase
			end
			CMD_WRITE: begin
				unique case (ofs_word)
					OFS_DATA:  out_data_d = wval;
					OFS_DIR:   direction_d = wval;
					OFS_INTEN: begin
						irq_enable_d   = wval;
						edge_latched_d = edge_latched_q & wval & irq_is_edge_q;
					end
					OFS_TYPE: begin
						irq_is_edge_d  = wval;
						edge_latched_d = edge_latched_q & irq_enable_q & wval;
					end
					OFS_POL:   irq_polarity_d = wval;
					OFS_EOI:   edge_latched_d = edge_latched_q & ~wval;
					default:   ;
				endcase
			end
			CMD_SAMPLE: begin
				edge_latched_d = edge_latched_q | (hit & irq_enable_q & irq_is_edge_q);
				last_pins_d    = now_pins;
			end
			default: ;
		endcase
	end

	assign status_nxt = irq_enable_d & PIN_MASK &
		((~irq_is_edge_d & ~(last_pins_d ^ irq_polarity_d)) | (irq_is_edge_d & edge_latched_d));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			out_data_q     <= '0;
			direction_q    <= '0;
			irq_enable_q   <= '0;
			irq_is_edge_q  <= '0;
			irq_polarity_q <= '0;
			edge_latched_q <= '0;
			last_pins_q    <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (step) begin
				out_data_q     <= out_data_d;
				direction_q    <= direction_d;
				irq_enable_q   <= irq_enable_d;
				irq_is_edge_q  <= irq_is_edge_d;
				irq_polarity_q <= irq_polarity_d;
				edge_latched_q <= edge_latched_d;
				last_pins_q    <= last_pins_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			command_s1    <= req.command;
			reg_offset_s1 <= req.reg_offset;
			write_data_s1 <= req.write_data;
			pins_in_s1    <= req.pins_in;
		end
		if (step) begin
			read_data_q <= rdata;
			pins_out_q  <= out_data_d;
			pins_dir_q  <= direction_d;
			irq_q       <= |status_nxt;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = read_data_q;
	assign rsp.pins_out  = pins_out_q;
	assign rsp.pins_dir  = pins_dir_q;
	assign rsp.irq       = irq_q;

endmodule

FILE: hdl/gpio_chk.sv
`include "gpio_port_with_interrupt_detect_top_macros.svh"

module gpio_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_read_data,
	input logic [31:0] rsp_pins_out,
	input logic [31:0] rsp_pins_dir,
	input logic        rsp_irq
);

	// stalled result word holds
	`GPIO_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_pins_out) && $stable(rsp_pins_dir) && $stable(rsp_irq), "rsp word changed while stalled")

	// empty result register never blocks the input
	`GPIO_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready, "req stalled with empty result register")

	// an accepted word shows a result after the input register and the result register
	`GPIO_ASSERT(a_latency, req_valid && req_ready |-> ##2 rsp_valid, "no result two cycles after accept")

endmodule

bind gpio_port_with_interrupt_detect_top gpio_chk u_gpio_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_data (rsp.read_data),
	.rsp_pins_out  (rsp.pins_out),
	.rsp_pins_dir  (rsp.pins_dir),
	.rsp_irq       (rsp.irq)
);
